// ===== src/cxp_pkg.sv =====
// Shared types, constants and helpers for the color transform record parser.
// Depends on nothing; used by color_transform_record_parser and tb_top.
`timescale 1ns / 1ps

package cxp_pkg;

  // Field widths
  localparam int unsigned TermW    = 15;
  localparam int unsigned HdrW     = 6;
  localparam int unsigned CountW   = 4;
  localparam int unsigned SlotCnt  = 8;
  localparam int unsigned SlotAw   = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned OutUserW = 2;

  // Header layout: add flag, multiply flag, 4-bit width
  localparam int unsigned HdrAddBit  = 5;
  localparam int unsigned HdrMultBit = 4;

  // Defaults of absent terms
  localparam logic [TermW-1:0] MultOne = 15'd256;
  localparam logic [TermW-1:0] AddZero = 15'd0;

  // Terms per kind
  localparam logic [2:0] TermsRgb  = 3'd3;
  localparam logic [2:0] TermsRgba = 3'd4;

  // Header length in bits
  localparam logic [CountW-1:0] HdrLen = 4'd6;

  // Parse phases, one-hot
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_TERMS  = 3'b100
  } phase_t;

  // Sign-extend the low n bits of an accumulated term to the full term width
  function automatic logic [TermW-1:0] sext_term(input logic [TermW-1:0] acc,
                                                 input logic [CountW-1:0] n);
    logic [TermW-1:0] v;
    logic             sgn;
    sgn = acc[n - 4'd1];
    for (int j = 0; j < TermW; j++) begin
      v[j] = (4'(j) < n) ? acc[j] : sgn;
    end
    return v;
  endfunction

endpackage

// ===== src/color_transform_record_parser.sv =====
// Color transform record parser: one stream byte per cycle in, stalled while a result
// waits untaken; one register of decoded multiply/add terms out. Depends on cxp_pkg.
`timescale 1ns / 1ps
// Throughput: one byte per clock, sustained; a new byte is taken while a result
//   waits in the output register, as long as that result is taken the same cycle.
// A result is registered: it is valid in the cycle after the byte that ends its record.
// The per-byte work is an eight-step unrolled bit extract chain between the
//   parse state registers and the output register.
// Reset (rst_n low, synchronous): parser idles awaiting a record start, output empty.

module color_transform_record_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cxp_pkg::InDataW-1:0]    in_tdata,   // [7:0] data_byte
  input  logic [cxp_pkg::InUserW-1:0]    in_tuser,   // [0] record_start, [1] with_alpha
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [3:0] term_bits, [18:4] red_mult, [33:19] green_mult, [48:34] blue_mult,
  // [63:49] alpha_mult, [78:64] red_add, [93:79] green_add, [108:94] blue_add,
  // [123:109] alpha_add, [127:124] zero
  output logic [cxp_pkg::OutDataW-1:0]   out_tdata,
  output logic [cxp_pkg::OutUserW-1:0]   out_tuser   // [0] has_mult, [1] has_add
);

  // Parse state
  cxp_pkg::phase_t                 phase_r, phase_nxt;
  logic [cxp_pkg::HdrW-1:0]        hdr_r, hdr_nxt;
  logic [cxp_pkg::TermW-1:0]       acc_r, acc_nxt;
  logic [cxp_pkg::CountW-1:0]      cnt_r, cnt_nxt;
  logic [cxp_pkg::CountW-1:0]      idx_r, idx_nxt;
  logic                            alpha_r, alpha_nxt;
  // Term slots: multiply terms in 0..3, add terms in 4..7 (no reset, written before read)
  logic [cxp_pkg::TermW-1:0]       slot_r   [cxp_pkg::SlotCnt];
  logic [cxp_pkg::TermW-1:0]       slot_nxt [cxp_pkg::SlotCnt];
  logic                            done;

  // Output register
  logic                            out_valid_r;
  logic [cxp_pkg::OutDataW-1:0]    out_data_r, out_data_nxt;
  logic [cxp_pkg::OutUserW-1:0]    out_user_r, out_user_nxt;

  logic                            in_acc;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Unrolled bit walk over one byte, MSB first
  always_comb begin
    logic [2:0]                 k;
    logic [2:0]                 mult_cnt;
    logic [3:0]                 tot;
    logic                       b;
    logic [3:0]                 rel;
    logic [cxp_pkg::SlotAw-1:0] waddr;
    logic [cxp_pkg::TermW-1:0]  m_t;
    logic [cxp_pkg::TermW-1:0]  a_t;

    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    alpha_nxt = alpha_r;
    for (int s = 0; s < cxp_pkg::SlotCnt; s++) begin
      slot_nxt[s] = slot_r[s];
    end
    done = 1'b0;

    // record start aborts any partial record
    if (in_tuser[0]) begin
      phase_nxt = cxp_pkg::PH_HEADER;
      hdr_nxt   = '0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      idx_nxt   = '0;
      alpha_nxt = in_tuser[1];
    end

    k        = alpha_nxt ? cxp_pkg::TermsRgba : cxp_pkg::TermsRgb;
    mult_cnt = 3'd0;
    tot      = 4'd0;

    for (int i = cxp_pkg::InDataW - 1; i >= 0; i--) begin
      b        = in_tdata[i];
      mult_cnt = hdr_nxt[cxp_pkg::HdrMultBit] ? k : 3'd0;
      tot      = {1'b0, mult_cnt} + (hdr_nxt[cxp_pkg::HdrAddBit] ? {1'b0, k} : 4'd0);
      rel      = '0;
      waddr    = '0;
      unique case (phase_nxt)
        cxp_pkg::PH_HEADER: begin
          hdr_nxt = {hdr_nxt[cxp_pkg::HdrW-2:0], b};
          cnt_nxt = cnt_nxt + 4'd1;
          if (cnt_nxt == cxp_pkg::HdrLen) begin
            mult_cnt = hdr_nxt[cxp_pkg::HdrMultBit] ? k : 3'd0;
            tot      = {1'b0, mult_cnt} +
                       (hdr_nxt[cxp_pkg::HdrAddBit] ? {1'b0, k} : 4'd0);
            cnt_nxt  = '0;
            acc_nxt  = '0;
            idx_nxt  = '0;
            // no terms, or zero width: record ends after its header
            if (tot == 4'd0 || hdr_nxt[3:0] == 4'd0) begin
              for (int s = 0; s < cxp_pkg::SlotCnt; s++) begin
                slot_nxt[s] = '0;
              end
              idx_nxt   = tot;
              done      = 1'b1;
              phase_nxt = cxp_pkg::PH_IDLE;
            end else begin
              phase_nxt = cxp_pkg::PH_TERMS;
            end
          end
        end
        cxp_pkg::PH_TERMS: begin
          acc_nxt = {acc_nxt[cxp_pkg::TermW-2:0], b};
          cnt_nxt = cnt_nxt + 4'd1;
          if (cnt_nxt == hdr_nxt[3:0]) begin
            // multiply terms land in the low slots, add terms in the high ones
            if (idx_nxt < {1'b0, mult_cnt}) begin
              waddr = {1'b0, idx_nxt[1:0]};
            end else begin
              rel   = idx_nxt - {1'b0, mult_cnt};
              waddr = {1'b1, rel[1:0]};
            end
            slot_nxt[waddr] = cxp_pkg::sext_term(acc_nxt, hdr_nxt[3:0]);
            idx_nxt = idx_nxt + 4'd1;
            acc_nxt = '0;
            cnt_nxt = '0;
            if (idx_nxt >= tot) begin
              done      = 1'b1;
              phase_nxt = cxp_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end

    // result assembly
    out_user_nxt = {hdr_nxt[cxp_pkg::HdrAddBit], hdr_nxt[cxp_pkg::HdrMultBit]};
    out_data_nxt = '0;
    out_data_nxt[3:0] = hdr_nxt[3:0];
    for (int c = 0; c < 4; c++) begin
      m_t = cxp_pkg::MultOne;
      a_t = cxp_pkg::AddZero;
      if (3'(c) < k) begin
        if (hdr_nxt[cxp_pkg::HdrMultBit]) m_t = slot_nxt[c];
        if (hdr_nxt[cxp_pkg::HdrAddBit])  a_t = slot_nxt[4 + c];
      end
      out_data_nxt[4 + c*cxp_pkg::TermW +: cxp_pkg::TermW]      = m_t;
      out_data_nxt[4 + (c+4)*cxp_pkg::TermW +: cxp_pkg::TermW]  = a_t;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cxp_pkg::PH_IDLE;
      hdr_r   <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      alpha_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  // Term slots
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int s = 0; s < cxp_pkg::SlotCnt; s++) begin
        slot_r[s] <= slot_nxt[s];
      end
    end
  end

  // Output register: load on a completing transaction, drain on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && done) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  // Checks
  a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_tvalid && in_tready))
    else $error("result appeared without an input transaction");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 4'd8)
    else $error("term index beyond eight");

  a_terms_width: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cxp_pkg::PH_TERMS |-> hdr_r[3:0] != 4'd0)
    else $error("term phase with zero field width");

  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |=> phase_r == cxp_pkg::PH_IDLE)
    else $error("parser not idle after record end");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for color_transform_record_parser: stream driver, result monitor
// and a bit-serial record decoder that predicts every result. Depends on cxp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import cxp_pkg::*;

  localparam int LongHoldAt     = 30;   // result count at which the receiver holds off
  localparam int LongHoldCycles = 300;
  localparam int RandomItems    = 600;

  // One decoded record, channel order red, green, blue, alpha
  typedef struct packed {
    logic                      has_mult;
    logic                      has_add;
    logic [3:0]                term_bits;
    logic [3:0][TermW-1:0]     mult;
    logic [3:0][TermW-1:0]     add;
  } xform_t;

  // One stream byte to send; hold makes the sender wait for all results first
  typedef struct packed {
    logic       hold;
    logic       alpha;
    logic       start;
    logic [7:0] data;
  } byte_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata = '0;    // [7:0] data_byte
  logic [InUserW-1:0]   in_tuser = '0;    // [0] record_start, [1] with_alpha
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;        // term_bits, mult terms, add terms
  logic [OutUserW-1:0]  out_tuser;        // [0] has_mult, [1] has_add

  color_transform_record_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  byte_item_t   stream_q[$];
  xform_t       xform_q[$];
  int           errors = 0;
  int           results_seen = 0;
  int           src_gap = 0;
  int           snk_wait = 0;
  bit           src_burst = 0;
  bit           snk_burst = 0;
  byte_item_t   nxt_item;
  xform_t       got_x;
  logic [TermW-1:0] term_vals [8];
  int           rec_items = 0;
  string        chan_name [4] = '{"red", "green", "blue", "alpha"};

  // Decoder state
  phase_t            dec_phase = PH_IDLE;
  logic [HdrW-1:0]   dec_hdr = '0;
  logic [TermW-1:0]  dec_acc = '0;
  logic [CountW-1:0] dec_nbits = '0;
  logic [CountW-1:0] dec_fidx = '0;
  logic              dec_alpha = 1'b0;
  logic [TermW-1:0]  dec_terms [SlotCnt];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Record decoder
  // ---------------------------------------------------------------------------

  function automatic int terms_in_record();
    int k;
    k = dec_alpha ? int'(TermsRgba) : int'(TermsRgb);
    return (dec_hdr[HdrMultBit] ? k : 0) + (dec_hdr[HdrAddBit] ? k : 0);
  endfunction

  // Sign-extend an n-bit term to the full term width
  function automatic logic [TermW-1:0] widen_term(logic [TermW-1:0] acc, logic [3:0] n);
    if (acc[n - 4'd1])
      return acc | (15'h7fff << n);
    return acc;
  endfunction

  task automatic push_xform();
    xform_t x;
    int     k;
    int     add_base;
    k = dec_alpha ? int'(TermsRgba) : int'(TermsRgb);
    add_base = dec_hdr[HdrMultBit] ? k : 0;
    x.has_mult  = dec_hdr[HdrMultBit];
    x.has_add   = dec_hdr[HdrAddBit];
    x.term_bits = dec_hdr[3:0];
    for (int c = 0; c < 4; c++) begin
      x.mult[c] = MultOne;
      x.add[c]  = AddZero;
      if (c < k) begin
        if (x.has_mult) x.mult[c] = dec_terms[c];
        if (x.has_add) x.add[c] = dec_terms[(add_base + c) % SlotCnt];
      end
    end
    xform_q.push_back(x);
  endtask

  // Consume one accepted byte, MSB first; may complete one record
  task automatic decode_stream_byte(logic [7:0] b, logic st, logic al);
    logic [3:0] w;
    bit         done;
    done = 0;
    if (st) begin
      dec_phase = PH_HEADER;
      dec_hdr   = '0;
      dec_acc   = '0;
      dec_nbits = '0;
      dec_fidx  = '0;
      dec_alpha = al;
    end
    for (int i = 7; i >= 0 && !done; i--) begin
      w = dec_hdr[3:0];
      case (dec_phase)
        PH_HEADER: begin
          dec_hdr   = {dec_hdr[HdrW-2:0], b[i]};
          dec_nbits = dec_nbits + 4'd1;
          if (dec_nbits >= HdrLen) begin
            dec_nbits = '0;
            dec_acc   = '0;
            dec_fidx  = '0;
            // Header-only record: no flags or zero width
            if (terms_in_record() == 0 || dec_hdr[3:0] == 4'd0) begin
              for (int j = 0; j < SlotCnt; j++) dec_terms[j] = '0;
              push_xform();
              dec_phase = PH_IDLE;
              done = 1;
            end else begin
              dec_phase = PH_TERMS;
            end
          end
        end
        PH_TERMS: begin
          dec_acc   = {dec_acc[TermW-2:0], b[i]};
          dec_nbits = dec_nbits + 4'd1;
          if (dec_nbits >= w) begin
            dec_terms[dec_fidx[2:0]] = widen_term(dec_acc, w);
            dec_fidx  = dec_fidx + 4'd1;
            dec_acc   = '0;
            dec_nbits = '0;
            if (int'(dec_fidx) >= terms_in_record()) begin
              push_xform();
              dec_phase = PH_IDLE;
              done = 1;
            end
          end
        end
        default: done = 1;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic logic [TermW-1:0] pick_term(logic [3:0] w);
    case ($urandom_range(0, 4))
      0: return (15'h7fff >> (16 - w));      // largest positive
      1: return 15'd1 << (w - 4'd1);         // most negative
      2: return 15'h7fff;                    // minus one
      default: return 15'($urandom);
    endcase
  endfunction

  // Pack a record MSB first into bytes; cut > 0 keeps only that many bytes
  task automatic push_record(logic al, logic hm, logic ha, logic [3:0] w, int cut,
                             bit drain);
    bit         bitq[$];
    int         k;
    int         t;
    int         nb;
    byte_item_t it;
    k = al ? int'(TermsRgba) : int'(TermsRgb);
    t = (hm ? k : 0) + (ha ? k : 0);
    bitq.push_back(ha);
    bitq.push_back(hm);
    for (int j = 3; j >= 0; j--) bitq.push_back(w[j]);
    if (w != 4'd0)
      for (int i = 0; i < t; i++)
        for (int j = int'(w) - 1; j >= 0; j--) bitq.push_back(term_vals[i][j]);
    while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom));
    nb = bitq.size() / 8;
    if (cut > 0 && cut < nb) nb = cut;
    for (int i = 0; i < nb; i++) begin
      for (int j = 0; j < 8; j++) it.data[7 - j] = bitq[i * 8 + j];
      it.start = (i == 0);
      it.alpha = (i == 0) ? al : 1'($urandom);
      it.hold  = (i == 0) && drain;
      stream_q.push_back(it);
    end
    rec_items += nb;
  endtask

  task automatic push_loose_byte(logic [7:0] d, logic st, logic al);
    byte_item_t it;
    it.data  = d;
    it.start = st;
    it.alpha = al;
    it.hold  = 1'b0;
    stream_q.push_back(it);
  endtask

  task automatic build_random_stream();
    logic       al;
    logic       hm;
    logic       ha;
    logic [3:0] w;
    int         kind;
    bit         first;
    first = 1;
    while (rec_items < RandomItems) begin
      kind = $urandom_range(0, 19);
      al = 1'($urandom);
      hm = 1'($urandom);
      ha = 1'($urandom);
      w  = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      for (int i = 0; i < SlotCnt; i++) term_vals[i] = pick_term(w);
      if (kind == 0) begin
        // Noise: loose bytes, now and then a start on random content
        repeat ($urandom_range(1, 3))
          push_loose_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
      end else if (kind <= 2) begin
        // Record cut to at most four bytes, broken when it is longer than that
        push_record(al, hm, ha, w, $urandom_range(1, 4), 0);
      end else begin
        push_record(al, hm, ha, w, 0, first || $urandom_range(0, 59) == 0);
        first = 0;
        if ($urandom_range(0, 7) == 0) push_loose_byte(8'($urandom), 1'b0, 1'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one input transaction per accepted byte
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_stream_byte(in_tdata, in_tuser[0], in_tuser[1]);
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        src_gap = src_burst ? 0 : $urandom_range(0, 6);
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transaction
      end else if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (stream_q.size() != 0 && !(stream_q[0].hold && xform_q.size() != 0)) begin
        nxt_item = stream_q.pop_front();
        in_tdata  <= nxt_item.data;
        in_tuser  <= {nxt_item.alpha, nxt_item.start};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic compare_xform(xform_t want, xform_t got);
    if (want.has_mult !== got.has_mult) begin
      $display("%0t: has_mult expected %0d got %0d", $time, want.has_mult, got.has_mult);
      errors++;
    end
    if (want.has_add !== got.has_add) begin
      $display("%0t: has_add expected %0d got %0d", $time, want.has_add, got.has_add);
      errors++;
    end
    if (want.term_bits !== got.term_bits) begin
      $display("%0t: term_bits expected %0d got %0d", $time, want.term_bits, got.term_bits);
      errors++;
    end
    for (int c = 0; c < 4; c++) begin
      if (want.mult[c] !== got.mult[c]) begin
        $display("%0t: %s_mult expected %0d got %0d", $time, chan_name[c],
                 $signed(want.mult[c]), $signed(got.mult[c]));
        errors++;
      end
      if (want.add[c] !== got.add[c]) begin
        $display("%0t: %s_add expected %0d got %0d", $time, chan_name[c],
                 $signed(want.add[c]), $signed(got.add[c]));
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_x.has_mult  = out_tuser[0];
        got_x.has_add   = out_tuser[1];
        got_x.term_bits = out_tdata[3:0];
        for (int c = 0; c < 4; c++) begin
          got_x.mult[c] = out_tdata[4 + TermW * c +: TermW];
          got_x.add[c]  = out_tdata[64 + TermW * c +: TermW];
        end
        if (xform_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %h / %h", $time,
                   out_tuser, out_tdata);
          errors++;
        end else begin
          compare_xform(xform_q.pop_front(), got_x);
        end
        results_seen++;
        if ($urandom_range(0, 29) == 0) snk_burst = !snk_burst;
        if (results_seen == LongHoldAt)
          snk_wait = LongHoldCycles;
        else
          snk_wait = snk_burst ? 0 : $urandom_range(0, 6);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    // Idle byte before any record
    push_loose_byte(8'ha5, 1'b0, 1'b1);
    // No flags, RGB and RGBA
    push_record(1'b0, 1'b0, 1'b0, 4'd5, 0, 0);
    push_record(1'b1, 1'b0, 1'b0, 4'd15, 0, 0);
    // Both flags with zero width
    push_record(1'b1, 1'b1, 1'b1, 4'd0, 0, 0);
    // One-bit multiply terms
    term_vals = '{15'd1, 15'd0, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
    push_record(1'b0, 1'b1, 1'b0, 4'd1, 0, 0);
    // Full-width add terms at the extremes
    term_vals = '{15'h3fff, 15'h4000, 15'h7fff, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
    push_record(1'b0, 1'b0, 1'b1, 4'd15, 0, 0);
    // Record aborted by the next start
    push_record(1'b1, 1'b1, 1'b1, 4'd8, 2, 0);
    // Both kinds, RGBA, two-bit terms; sender waits for all results first
    term_vals = '{15'd2, 15'd1, 15'd3, 15'd0, 15'd1, 15'd2, 15'd3, 15'd0};
    push_record(1'b1, 1'b1, 1'b1, 4'd2, 0, 1);
    // Trailing bytes with no record open
    push_loose_byte(8'h00, 1'b0, 1'b0);
    push_loose_byte(8'hff, 1'b0, 1'b1);
    rec_items = 0;
    build_random_stream();

    wait (rst_n);
    // Sample after the edge has settled so the driver's updates are visible
    while (stream_q.size() != 0 || in_tvalid || xform_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS color_transform_record_parser");
    end else begin
      $display("FAIL color_transform_record_parser");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL color_transform_record_parser");
    $finish;
  end

endmodule
